### rtl/core/legb_pkg.sv
// Shared constants, codes and control structs for the line editor gap buffer.
package legb_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int DATA_W     = 8;
    localparam int MODE_W     = 2;

    localparam logic [MODE_W-1:0] MODE_KEY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [DATA_W-1:0] KEY_LEFT  = 8'h3C;
    localparam logic [DATA_W-1:0] KEY_RIGHT = 8'h3E;
    localparam logic [DATA_W-1:0] KEY_BACK  = 8'h2D;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic move_wr;   // second half of a cursor move
        logic out_load;  // load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_move; // current beat is a cursor move with text to move
        logic is_read;   // current beat is a read
    } t_dp_stat;

endpackage

### rtl/core/line_edit_gap_buffer.sv
// Top level of the keystroke line editor built on a gap buffer.
//
// Line editor holding up to LINE_DEPTH (256) characters as a gap buffer in
// one registered-read RAM: text left of the cursor grows up from address 0,
// text right of it grows down from the top. Mode 0 beats are keystrokes:
// '<' and '>' move the cursor when text is there, '-' deletes the character
// before the cursor, any other byte is inserted; an insert into a full line
// is dropped and sets a sticky overflow flag. Mode 1 beats read the line
// back one character per beat, flagging the last one (an empty line gives a
// single beat with line_empty and last_char set). Mode 2 clears the line and
// the overflow flag; mode 3 is ignored. Only reads produce an output beat.
// Insert, delete, clear and ignored beats need only the idle state; a cursor
// move adds the move state (RAM read, then write to the far side of the gap);
// a read adds the read state, which waits while the sink holds the result.
// One beat is in flight at a time, set by the single RAM read-then-write.
// The result register lets the block take the next beat while a result is
// held. The store needs no clearing after reset.
module line_edit_gap_buffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input beats
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [legb_pkg::MODE_W-1:0]  i_mode,
    input  logic [legb_pkg::DATA_W-1:0]  i_key,
    // result beats
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [legb_pkg::DATA_W-1:0]  o_char_out,
    output logic                         o_line_empty,
    output logic                         o_last_char,
    output logic                         o_overflowed
);
    import legb_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing: one-hot FSM, decides when beats are taken and results loaded
    legb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // counters, text store and result registers
    legb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_char_out   (o_char_out),
        .o_line_empty (o_line_empty),
        .o_last_char  (o_last_char),
        .o_overflowed (o_overflowed)
    );

endmodule

### rtl/core/legb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module legb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/legb_dp.sv
// Datapath: cursor counters, read position, text store and result registers.
module legb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [legb_pkg::MODE_W-1:0]   i_mode,
    input  logic [legb_pkg::DATA_W-1:0]   i_key,
    input  legb_pkg::t_dp_cmd             i_cmd,
    output legb_pkg::t_dp_stat            o_stat,
    output logic [legb_pkg::DATA_W-1:0]   o_char_out,
    output logic                          o_line_empty,
    output logic                          o_last_char,
    output logic                          o_overflowed
);
    import legb_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_right, n_right;
    logic [CNT_W-1:0]  r_rpos, n_rpos;
    logic              r_ovf, n_ovf;
    logic [ADDR_W-1:0] r_waddr;
    logic              r_p_empty, r_p_last;
    logic [DATA_W-1:0] r_char;
    logic              r_empty, r_last, r_ovf_out;

    logic [CNT_W-1:0]  total, pos, line_addr;
    logic              full, empty, last;
    logic              is_key, mv_left, mv_right, is_insert;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr, move_waddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    always_comb begin
        total     = r_left + r_right;
        full      = (total == DEPTH_C);
        empty     = (total == '0);
        pos       = (r_rpos >= total) ? '0 : r_rpos;
        last      = ((pos + ONE_C) == total);
        // left text sits at its own position; right text at DEPTH-right .. DEPTH-1,
        // so past the left text the offset is DEPTH-total
        line_addr = (pos < r_left) ? pos : pos + (DEPTH_C - total);

        is_key    = (i_mode == MODE_KEY);
        mv_left   = is_key && (i_key == KEY_LEFT) && (r_left != '0);
        mv_right  = is_key && (i_key == KEY_RIGHT) && (r_right != '0);
        is_insert = is_key && (i_key != KEY_LEFT) && (i_key != KEY_RIGHT)
                    && (i_key != KEY_BACK);

        o_stat.need_move = mv_left || mv_right;
        o_stat.is_read   = (i_mode == MODE_READ);

        if (mv_left) begin
            ram_raddr  = ADDR_W'(r_left - ONE_C);
            move_waddr = ADDR_W'(DEPTH_C - r_right - ONE_C);
        end else if (mv_right) begin
            ram_raddr  = ADDR_W'(DEPTH_C - r_right);
            move_waddr = ADDR_W'(r_left);
        end else begin
            ram_raddr  = ADDR_W'(line_addr);
            move_waddr = ADDR_W'(r_left);
        end
        ram_re = i_cmd.accept && (mv_left || mv_right || (o_stat.is_read && !empty));

        ram_we    = i_cmd.move_wr || (i_cmd.accept && is_insert && !full);
        ram_waddr = i_cmd.move_wr ? r_waddr : ADDR_W'(r_left);
        ram_wdata = i_cmd.move_wr ? ram_rdata : i_key;

        n_left  = r_left;
        n_right = r_right;
        n_rpos  = r_rpos;
        n_ovf   = r_ovf;
        if (i_cmd.accept) begin
            case (i_mode)
                MODE_KEY: begin
                    n_rpos = '0;
                    if (mv_left) begin
                        n_left  = r_left - ONE_C;
                        n_right = r_right + ONE_C;
                    end else if (mv_right) begin
                        n_left  = r_left + ONE_C;
                        n_right = r_right - ONE_C;
                    end else if (i_key == KEY_BACK) begin
                        if (r_left != '0) begin
                            n_left = r_left - ONE_C;
                        end
                    end else if (is_insert) begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_left = r_left + ONE_C;
                        end
                    end
                end
                MODE_READ: begin
                    n_rpos = (empty || last) ? '0 : pos + ONE_C;
                end
                MODE_CLEAR: begin
                    n_left  = '0;
                    n_right = '0;
                    n_rpos  = '0;
                    n_ovf   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_rpos  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_right <= n_right;
            r_rpos  <= n_rpos;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_waddr   <= move_waddr;
            r_p_empty <= empty;
            r_p_last  <= empty || last;
        end
        if (i_cmd.out_load) begin
            r_char    <= r_p_empty ? '0 : ram_rdata;
            r_empty   <= r_p_empty;
            r_last    <= r_p_last;
            r_ovf_out <= r_ovf;
        end
    end

    legb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_char_out   = r_char;
    assign o_line_empty = r_empty;
    assign o_last_char  = r_last;
    assign o_overflowed = r_ovf_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left + r_right) <= DEPTH_C)
        else $error("gap buffer holds more than its depth");

    a_rpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rpos == '0) || (r_rpos < total))
        else $error("read position beyond line length");

    a_move_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.accept && i_cmd.move_wr))
        else $error("move write overlaps a new beat");

endmodule

### rtl/core/legb_ctrl.sv
// Controller: sequences each beat and owns the result valid flag.
module legb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  legb_pkg::t_dp_stat  i_stat,
    output legb_pkg::t_dp_cmd   o_cmd
);
    import legb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOVE = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    always_comb begin
        out_free       = !r_out_vld || !i_out_stall;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.move_wr  = (r_state == S_MOVE);
        o_cmd.out_load = (r_state == S_READ) && out_free;

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    if (i_stat.need_move) begin
                        n_state = S_MOVE;
                    end else if (i_stat.is_read) begin
                        n_state = S_READ;
                    end
                end
            end
            S_MOVE: begin
                n_state = S_IDLE;
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !o_cmd.out_load)
        else $error("held result overwritten");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.is_read) |=> (r_state == S_READ))
        else $error("read beat did not reach read state");

endmodule

### tb/tb.sv
// Self-checking testbench for the gap-buffer line editor: mirror, stimulus and checks.

// One read beat as the block should return it.
typedef struct packed {
    logic [legb_pkg::DATA_W-1:0] ch;
    logic                        empty;
    logic                        last;
    logic                        ovf;
} t_read_beat;

// Mirror of the editor's line. It replays every accepted input beat and holds
// the read beats still owed by the block.
class gap_line_mirror;
    logic [legb_pkg::DATA_W-1:0] text_mem [legb_pkg::LINE_DEPTH];
    logic [legb_pkg::CNT_W-1:0]  left_len;
    logic [legb_pkg::CNT_W-1:0]  right_len;
    logic [legb_pkg::CNT_W-1:0]  read_pos;
    logic                        ovf_sticky;
    t_read_beat                  pending_reads[$];
    int mismatches;
    int n_keys;
    int n_reads;
    int n_clears;
    int n_ignored;
    int n_dropped;
    int n_full;
    int n_compared;

    function new();
        foreach (text_mem[i]) text_mem[i] = '0;
        left_len   = '0;
        right_len  = '0;
        read_pos   = '0;
        ovf_sticky = 1'b0;
        mismatches = 0;
        n_keys     = 0;
        n_reads    = 0;
        n_clears   = 0;
        n_ignored  = 0;
        n_dropped  = 0;
        n_full     = 0;
        n_compared = 0;
    endfunction

    function int line_len();
        return int'(left_len) + int'(right_len);
    endfunction

    function logic [legb_pkg::DATA_W-1:0] char_at(int pos);
        if (pos < int'(left_len))
            return text_mem[pos];
        return text_mem[legb_pkg::LINE_DEPTH - int'(right_len) + pos - int'(left_len)];
    endfunction

    // Apply one accepted input beat.
    function void take_beat(logic [legb_pkg::MODE_W-1:0] mode,
                            logic [legb_pkg::DATA_W-1:0] key);
        t_read_beat exp;
        int total;
        int gap_top;
        total   = line_len();
        gap_top = legb_pkg::LINE_DEPTH - int'(right_len);
        case (mode)
            legb_pkg::MODE_KEY: begin
                n_keys++;
                read_pos = '0;
                if (key == legb_pkg::KEY_LEFT) begin
                    if (left_len != 0) begin
                        left_len--;
                        right_len++;
                        text_mem[gap_top - 1] = text_mem[left_len];
                    end
                end else if (key == legb_pkg::KEY_RIGHT) begin
                    if (right_len != 0) begin
                        text_mem[left_len] = text_mem[gap_top];
                        left_len++;
                        right_len--;
                    end
                end else if (key == legb_pkg::KEY_BACK) begin
                    if (left_len != 0)
                        left_len--;
                end else if (total >= legb_pkg::LINE_DEPTH) begin
                    ovf_sticky = 1'b1;
                    n_dropped++;
                end else begin
                    text_mem[left_len] = key;
                    left_len++;
                    if (line_len() == legb_pkg::LINE_DEPTH)
                        n_full++;
                end
            end
            legb_pkg::MODE_CLEAR: begin
                n_clears++;
                left_len   = '0;
                right_len  = '0;
                read_pos   = '0;
                ovf_sticky = 1'b0;
            end
            legb_pkg::MODE_READ: begin
                n_reads++;
                exp.ovf = ovf_sticky;
                if (total == 0) begin
                    read_pos  = '0;
                    exp.ch    = '0;
                    exp.empty = 1'b1;
                    exp.last  = 1'b1;
                end else begin
                    if (int'(read_pos) >= total)
                        read_pos = '0;
                    exp.ch    = char_at(int'(read_pos));
                    exp.empty = 1'b0;
                    if (int'(read_pos) + 1 == total) begin
                        exp.last = 1'b1;
                        read_pos = '0;
                    end else begin
                        exp.last = 1'b0;
                        read_pos++;
                    end
                end
                pending_reads.push_back(exp);
            end
            default: n_ignored++;
        endcase
    endfunction

    task flag_mismatch(string msg);
        mismatches++;
        $display("tb: mismatch: %s", msg);
    endtask

    // Compare one accepted result beat with the oldest owed read.
    task match_read(t_read_beat got);
        t_read_beat exp;
        if (pending_reads.size() == 0) begin
            flag_mismatch($sformatf("result beat with none owed, char %02h", got.ch));
        end else begin
            exp = pending_reads.pop_front();
            n_compared++;
            if (got.ch !== exp.ch)
                flag_mismatch($sformatf("read %0d char %02h, want %02h",
                                        n_compared, got.ch, exp.ch));
            if (got.empty !== exp.empty)
                flag_mismatch($sformatf("read %0d line_empty %b, want %b",
                                        n_compared, got.empty, exp.empty));
            if (got.last !== exp.last)
                flag_mismatch($sformatf("read %0d last_char %b, want %b",
                                        n_compared, got.last, exp.last));
            if (got.ovf !== exp.ovf)
                flag_mismatch($sformatf("read %0d overflowed %b, want %b",
                                        n_compared, got.ovf, exp.ovf));
        end
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import legb_pkg::*;

    // mode 3 has no name in the package; the block ignores it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int STUCK_LIMIT  = 1000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 8;     // settle time once nothing is owed
    localparam int RANDOM_ITEMS = 400;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [MODE_W-1:0] i_mode      = '0;
    logic [DATA_W-1:0] i_key       = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [DATA_W-1:0] o_char_out;
    logic              o_line_empty;
    logic              o_last_char;
    logic              o_overflowed;

    gap_line_mirror mirror = new();

    int stuck_cycles = 0;  // watchdog count, cleared by any accepted beat
    int sent_items   = 0;  // accepted input beats that the block acts on
    bit calm         = 1'b0;  // closing stretch: neither side idles
    int stall_left   = 0;
    int free_left    = 0;

    line_edit_gap_buffer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_out   (o_char_out),
        .o_line_empty (o_line_empty),
        .o_last_char  (o_last_char),
        .o_overflowed (o_overflowed)
    );

    always #2 i_clk = ~i_clk;

    // Monitor: both channels are sampled at the edge that takes the beat.
    // Values read here are the pre-edge ones, so the order of processes in
    // the step does not matter.
    always @(posedge i_clk) begin
        t_read_beat got;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                mirror.take_beat(i_mode, i_key);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                got.ch    = o_char_out;
                got.empty = o_line_empty;
                got.last  = o_last_char;
                got.ovf   = o_overflowed;
                mirror.match_read(got);
                moved = 1'b1;
            end
        end
        stuck_cycles <= moved ? 0 : stuck_cycles + 1;
    end

    // Result sink: stall bursts between free runs, some of the runs long, and
    // no stalls at all once the run is calm.
    always @(posedge i_clk) begin
        logic stall_nxt;
        if (calm) begin
            stall_left = 0;
            free_left  = 0;
            stall_nxt  = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            stall_nxt = 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            stall_nxt = 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            stall_nxt  = 1'b1;
        end else begin
            free_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(0, 20);
            stall_nxt = 1'b0;
        end
        i_out_stall <= stall_nxt;
    end

    // Watchdog: ends the run if the block stops moving.
    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // Random text byte, never one of the three control keys.
    function automatic logic [DATA_W-1:0] text_byte();
        logic [DATA_W-1:0] b;
        do
            b = DATA_W'($urandom_range(0, 255));
        while (b == KEY_LEFT || b == KEY_RIGHT || b == KEY_BACK);
        return b;
    endfunction

    // Mostly typing, with the odd cursor move or backspace.
    function automatic logic [DATA_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return KEY_LEFT;
            1:       return KEY_RIGHT;
            2:       return KEY_BACK;
            default: return text_byte();
        endcase
    endfunction

    task automatic idle_gap(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drive one input beat and hold it until the edge that takes it. Valid
    // stays high on return so back-to-back beats need no second assignment.
    task automatic send_beat(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] key);
        if (!calm && $urandom_range(0, 5) == 0)
            idle_gap($urandom_range(1, 14));
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        do
            @(posedge i_clk);
        while (o_in_stall);
        if (mode != MODE_UNUSED)
            sent_items++;
    endtask

    // Hold the sender off until every owed read beat has come back. The
    // mirror is looked at on the falling edge, clear of the monitor.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (mirror.pending_reads.size() != 0);
        @(posedge i_clk);
    endtask

    // Line length with every accepted beat applied; valid is dropped while it is read.
    task automatic line_length_now(output int len);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        len = mirror.line_len();
        @(posedge i_clk);
    endtask

    task automatic read_run(int n);
        repeat (n) send_beat(MODE_READ, DATA_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int rand_start;
        int len;
        int sel;
        bit paused;

        // reset: held low at the start, then released for good
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed beats ---
        send_beat(MODE_READ, 8'h00);      // empty line
        send_beat(MODE_KEY, KEY_LEFT);    // cursor moves and backspace with no text
        send_beat(MODE_KEY, KEY_RIGHT);
        send_beat(MODE_KEY, KEY_BACK);
        send_beat(MODE_READ, 8'hFF);
        send_beat(MODE_KEY, 8'h00);       // key extremes inserted as text
        send_beat(MODE_KEY, 8'hFF);
        send_beat(MODE_KEY, 8'h61);
        send_beat(MODE_KEY, KEY_LEFT);
        send_beat(MODE_KEY, KEY_LEFT);
        send_beat(MODE_KEY, KEY_LEFT);
        send_beat(MODE_KEY, KEY_LEFT);    // already at the start
        send_beat(MODE_KEY, KEY_RIGHT);
        read_run(4);                      // whole line, then wrap to the start
        send_beat(MODE_READ, 8'h00);
        send_beat(MODE_KEY, KEY_BACK);    // edit mid-read restarts the read
        send_beat(MODE_READ, 8'h00);
        send_beat(MODE_UNUSED, 8'hAA);    // ignored mode
        send_beat(MODE_READ, 8'h55);
        send_beat(MODE_CLEAR, 8'hFF);
        send_beat(MODE_READ, 8'h00);

        wait_results();

        // --- fill the line to the brim, with text on both sides of the gap ---
        send_beat(MODE_CLEAR, 8'h00);
        repeat (120) send_beat(MODE_KEY, text_byte());
        repeat (10) send_beat(MODE_KEY, KEY_LEFT);
        repeat (LINE_DEPTH - 120) send_beat(MODE_KEY, text_byte());
        repeat (3) send_beat(MODE_KEY, text_byte());   // dropped, flag set
        read_run(5);
        send_beat(MODE_KEY, KEY_RIGHT);   // moves still work when full
        send_beat(MODE_KEY, KEY_RIGHT);
        send_beat(MODE_KEY, KEY_LEFT);
        send_beat(MODE_KEY, KEY_LEFT);
        send_beat(MODE_KEY, KEY_BACK);
        send_beat(MODE_KEY, text_byte()); // full again
        send_beat(MODE_KEY, text_byte()); // dropped; flag stays set
        read_run(3);
        send_beat(MODE_CLEAR, 8'h00);     // clear drops the flag
        send_beat(MODE_READ, 8'h00);

        // --- random episodes ---
        rand_start = sent_items;
        paused     = 1'b0;
        while (sent_items - rand_start < RANDOM_ITEMS) begin
            if (!paused && sent_items - rand_start >= RANDOM_ITEMS / 2) begin
                wait_results();
                paused = 1'b1;
            end
            if (!calm && sent_items - rand_start >= RANDOM_ITEMS - 100)
                calm <= 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                repeat ($urandom_range(1, 12)) send_beat(MODE_KEY, pick_key());
            end else if (sel < 60) begin
                // read the whole line and one past it, or a short piece;
                // in the calm stretch the sender never pauses to look
                if (calm) begin
                    len = $urandom_range(1, 40);
                end else begin
                    line_length_now(len);
                    len = len + 1;
                    if (len > 40)
                        len = $urandom_range(1, 40);
                end
                read_run(len);
            end else if (sel < 72) begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 4))
                        0, 1:    send_beat(MODE_KEY, KEY_LEFT);
                        2, 3:    send_beat(MODE_KEY, KEY_RIGHT);
                        default: send_beat(MODE_KEY, KEY_BACK);
                    endcase
                end
            end else if (sel < 77) begin
                send_beat(MODE_CLEAR, DATA_W'($urandom_range(0, 255)));
            end else if (sel < 88) begin
                send_beat(MODE_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)));
            end else begin
                // read broken off by an edit
                read_run($urandom_range(1, 3));
                send_beat(MODE_KEY, pick_key());
                read_run($urandom_range(1, 2));
            end
        end

        // --- drain and finish ---
        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.pending_reads.size() != 0)
            mirror.flag_mismatch($sformatf("%0d read beats never returned",
                                           mirror.pending_reads.size()));

        $display("tb: ran %0d keystrokes, %0d reads, %0d clears, %0d ignored beats",
                 mirror.n_keys, mirror.n_reads, mirror.n_clears, mirror.n_ignored);
        $display("tb: %0d results compared, line full %0d times, %0d inserts dropped",
                 mirror.n_compared, mirror.n_full, mirror.n_dropped);
        if (mirror.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
